/* rtl/core/wsff_pkg.sv */
// ----------------------------------------------------------------------------
// wsff_pkg
// Shared types and constants of the frame fragmenter: field widths, header
// codes, sequencer step counts and the entry passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package wsff_pkg;

  // length counters and register widths
  localparam int LEN_W  = 32;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 32;

  // stream payload layout
  localparam int IN_DATA_W = BYTE_W + LEN_W;
  localparam int PADDR_W   = 3;

  // fragment size after reset
  localparam logic [CFG_W-1:0] MAXF_RESET = CFG_W'(32'h0001_0000);

  // header length codes and limits
  localparam logic [BYTE_W-1:0] LEN16_CODE  = 8'd126;
  localparam logic [BYTE_W-1:0] LEN64_CODE  = 8'd127;
  localparam logic [LEN_W-1:0]  SHORT_LIMIT = LEN_W'(126);
  localparam logic [LEN_W-1:0]  MID_LIMIT   = LEN_W'(32'h0001_0000);
  localparam int                LONG_BYTES  = 8;

  // sequencer steps: index of the payload byte for each header kind
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_HDR0      = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_CODE      = STEP_W'(1);
  localparam logic [STEP_W-1:0] LAST_STEP_NONE  = STEP_W'(0);
  localparam logic [STEP_W-1:0] LAST_STEP_SHORT = STEP_W'(2);
  localparam logic [STEP_W-1:0] LAST_STEP_MID   = STEP_W'(4);
  localparam logic [STEP_W-1:0] LAST_STEP_LONG  = STEP_W'(2 + LONG_BYTES);

  // front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_SHORT,
    HDR_MID,
    HDR_LONG
  } hdr_kind_t;

  // one classified input word
  typedef struct packed {
    logic [BYTE_W-1:0] payload;
    logic              ends_frame;
    hdr_kind_t         kind;
    logic              fin;
    logic              first;
    logic [LEN_W-1:0]  len;
  } frag_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

/* rtl/core/wsff_front.sv */
// ----------------------------------------------------------------------------
// wsff_front
// Accepts input words, tracks message and fragment counters and classifies
// each word: dropped, plain payload, or payload opening a new fragment.
// ----------------------------------------------------------------------------
`default_nettype none

module wsff_front
  import wsff_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  input  wire logic [IN_DATA_W-1:0] s_tdata,   // payload_byte, message_bytes
  input  wire logic                 s_tuser,   // starts_message
  input  wire logic [CFG_W-1:0]     max_frag,
  input  wire queue_status_t        q_status,
  output      logic                 push,
  output      frag_entry_t          push_entry
);

  logic [LEN_W-1:0] message_left, message_left_next;
  logic [LEN_W-1:0] fragment_left, fragment_left_next;
  logic             first_pending, first_pending_next;

  logic [LEN_W-1:0] msg_in, eff_msg, eff_frag, maxf, len, frag_now;
  logic             eff_first, need_hdr, accept;
  hdr_kind_t        kind;

  // classify the incoming word against the running counters
  always_comb begin
    msg_in    = s_tdata[IN_DATA_W-1:BYTE_W];
    eff_msg   = s_tuser ? msg_in : message_left;
    eff_frag  = s_tuser ? '0 : fragment_left;
    eff_first = s_tuser | first_pending;
    maxf      = (max_frag == '0) ? LEN_W'(1) : LEN_W'(max_frag);
    len       = (eff_msg <= maxf) ? eff_msg : maxf;
    need_hdr  = (eff_frag == '0);
    frag_now  = need_hdr ? len : eff_frag;

    if (!need_hdr) begin
      kind = HDR_NONE;
    end else if (len < SHORT_LIMIT) begin
      kind = HDR_SHORT;
    end else if (len < MID_LIMIT) begin
      kind = HDR_MID;
    end else begin
      kind = HDR_LONG;
    end

    s_tready = !q_status.full;
    accept   = s_tvalid && s_tready;
    push     = accept && (eff_msg != '0);

    push_entry.payload    = s_tdata[BYTE_W-1:0];
    push_entry.ends_frame = (frag_now == LEN_W'(1));
    push_entry.kind       = kind;
    push_entry.fin        = (eff_msg <= maxf);
    push_entry.first      = eff_first;
    push_entry.len        = len;

    message_left_next  = message_left;
    fragment_left_next = fragment_left;
    first_pending_next = first_pending;
    if (accept) begin
      if (eff_msg == '0) begin
        message_left_next  = '0;
        fragment_left_next = '0;
        first_pending_next = 1'b0;
      end else begin
        message_left_next  = eff_msg - LEN_W'(1);
        fragment_left_next = frag_now - LEN_W'(1);
        first_pending_next = need_hdr ? 1'b0 : eff_first;
      end
    end
  end

  // counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      message_left  <= '0;
      fragment_left <= '0;
      first_pending <= 1'b0;
    end else begin
      message_left  <= message_left_next;
      fragment_left <= fragment_left_next;
      first_pending <= first_pending_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wsff_queue.sv */
// ----------------------------------------------------------------------------
// wsff_queue
// Short queue of classified words between the front and the back sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module wsff_queue
  import wsff_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire frag_entry_t   push_entry,
  input  wire logic          pop,
  output      frag_entry_t   head,
  output      queue_status_t status
);

  frag_entry_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  // status and head word
  always_comb begin
    status.full  = (count == QCNT_W'(QUEUE_DEPTH));
    status.empty = (count == '0);
    do_push      = push && !status.full;
    do_pop       = pop && !status.empty;
    head         = entries[rd_ptr];
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  // fill count stays within the depth
  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // a lone push raises the count by one
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + QCNT_W'(1)))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

/* rtl/core/wsff_back.sv */
// ----------------------------------------------------------------------------
// wsff_back
// Header sequencer: walks the header bytes of the head word one per cycle while
// the output is not stalled, then emits its payload byte, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wsff_back
  import wsff_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire frag_entry_t       head,
  input  wire queue_status_t     q_status,
  output      logic              pop,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [BYTE_W-1:0] out_byte,
  output      logic              out_hdr,
  output      logic              out_ends,
  output      logic              out_last
);

  logic [STEP_W-1:0] step, step_next, last_step;
  logic              advance, is_last;
  logic [BYTE_W-1:0] byte_sel;
  logic [63:0]       len64;
  logic [2:0]        long_idx;

  // pick the byte for the current step
  always_comb begin
    unique case (head.kind)
      HDR_NONE:  last_step = LAST_STEP_NONE;
      HDR_SHORT: last_step = LAST_STEP_SHORT;
      HDR_MID:   last_step = LAST_STEP_MID;
      HDR_LONG:  last_step = LAST_STEP_LONG;
      default:   last_step = LAST_STEP_NONE;
    endcase
    is_last  = (step == last_step);
    len64    = 64'(head.len);
    long_idx = 3'(LAST_STEP_LONG - STEP_W'(1) - step);

    if (is_last) begin
      byte_sel = head.payload;
    end else if (step == STEP_HDR0) begin
      byte_sel = {head.fin, 6'b000000, head.first};
    end else if (head.kind == HDR_SHORT) begin
      byte_sel = head.len[BYTE_W-1:0];
    end else if (step == STEP_CODE) begin
      byte_sel = (head.kind == HDR_MID) ? LEN16_CODE : LEN64_CODE;
    end else if (head.kind == HDR_MID) begin
      byte_sel = (step == STEP_CODE + STEP_W'(1)) ? head.len[15:8] : head.len[7:0];
    end else begin
      byte_sel = len64[{long_idx, 3'b000} +: BYTE_W];
    end

    advance   = !q_status.empty && (!out_valid || out_ready);
    pop       = advance && is_last;
    step_next = step;
    if (advance) begin
      step_next = is_last ? '0 : step + STEP_W'(1);
    end
  end

  // step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= byte_sel;
      out_hdr  <= !is_last;
      out_ends <= is_last && head.ends_frame;
      out_last <= is_last;
    end
  end

  // step never runs past the longest header
  assert property (@(posedge clk) disable iff (rst) step <= LAST_STEP_LONG)
    else $error("sequencer step out of range");

  // the closing word of a run is payload, never header
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_last) |-> !out_hdr)
    else $error("header byte marked last of run");

  // end of fragment only on the closing payload byte
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_ends) |-> out_last)
    else $error("ends_frame on a header byte");

endmodule

`default_nettype wire

/* rtl/core/websocket_frame_fragmenter_unit.sv */
// ----------------------------------------------------------------------------
// websocket_frame_fragmenter_unit
// Frame header encoder with fragmentation for a byte stream of messages.
// ----------------------------------------------------------------------------
// Each input word is one payload byte; the first byte of a message carries
// the message length. A byte inside a fragment leaves as one output word. A
// byte that opens a fragment leaves behind its header: 3, 5 or 11 output
// words for lengths below 126, below 65536, or larger, one word per cycle
// from the header sequencer while the output is not stalled. The input
// side keeps accepting while a four-entry queue has room, so headers stall
// the input only once that queue fills. max_fragment_bytes sits at byte
// address 0; write it only while the block is idle.
`default_nettype none

module websocket_frame_fragmenter_unit
  import wsff_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  input  wire logic [IN_DATA_W-1:0] s_tdata,   // [7:0] payload_byte, [39:8] message_bytes
  input  wire logic                 s_tuser,   // [0] starts_message
  // output stream
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  output      logic [BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
  output      logic [1:0]           m_tuser,   // [0] is_header, [1] ends_frame
  output      logic                 m_tlast,   // last_of_run
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [CFG_W-1:0]     pwdata,
  output      logic [CFG_W-1:0]     prdata,
  output      logic                 pready
);

  logic [CFG_W-1:0] max_frag;
  logic             push, pop, hdr, ends;
  frag_entry_t      push_entry, head;
  queue_status_t    q_status;

  // register file
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == 1'b0) ? max_frag : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frag <= MAXF_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[PADDR_W-1] == 1'b0)) begin
      max_frag <= pwdata;
    end
  end

  wsff_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .max_frag   (max_frag),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  wsff_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  wsff_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_hdr   (hdr),
    .out_ends  (ends),
    .out_last  (m_tlast)
  );

  assign m_tuser = {ends, hdr};

endmodule

`default_nettype wire
